/* rtl/bbs_pkg.sv */
// shared types and constants for the bounding box and sphere block
`timescale 1ns / 1ps
package bbs_pkg;

	localparam int COORD_W    = 32;
	localparam int SQ_W       = 2 * COORD_W;
	localparam int ROOT_STEPS = SQ_W / 2;
	localparam int AXES       = 3;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t pos_x;
		coord_t pos_y;
		coord_t pos_z;
		logic   last_vertex;
	} bbs_vertex_t;

	typedef struct packed {
		coord_t               min_x;
		coord_t               min_y;
		coord_t               min_z;
		coord_t               max_x;
		coord_t               max_y;
		coord_t               max_z;
		coord_t               center_x;
		coord_t               center_y;
		coord_t               center_z;
		logic [COORD_W-1:0]   sphere_radius;
	} bbs_result_t;

	typedef struct packed {
		coord_t min_x;
		coord_t min_y;
		coord_t min_z;
		coord_t max_x;
		coord_t max_y;
		coord_t max_z;
	} bbs_box_t;

	typedef struct packed {
		logic start;
		logic ack;
	} bbs_rad_req_t;

	typedef struct packed {
		logic               done;
		coord_t             cen_x;
		coord_t             cen_y;
		coord_t             cen_z;
		logic [COORD_W-1:0] radius;
	} bbs_rad_rsp_t;

endpackage

/* rtl/bbs_stream_if.sv */
// valid/ready stream channel carrying one payload item
`timescale 1ns / 1ps
interface bbs_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* rtl/bounding_box_and_sphere_unit.sv */
// top level: running box update and result register around the radius unit
//
// Vertices enter on the vertex channel, one item per cycle while the block
// is ready. Each vertex widens the running per-axis min and max in the cycle
// it is accepted; the first vertex after reset or after a last vertex seeds
// them. A vertex marked last_vertex starts the result computation: the
// center, the three squared axis distances on one shared 32x32 multiplier
// and a 32-step bit-pair square root, one root bit per cycle.
// The block drops ready for that whole time, so the result item appears on
// the bounds channel once the root is done and the output register is free,
// and the next vertex can be taken in the cycle the result is registered.
// The result sits in an output register until taken; new vertices are
// accepted meanwhile, and only a further last vertex waits at the load step
// if the previous result has not been taken yet.
// Reset clears the handshake state and arms the first-vertex seed; the
// running bounds reset to zero.
`timescale 1ns / 1ps
module bounding_box_and_sphere_unit (
	input  logic         clk,
	input  logic         arst_n,
	bbs_stream_if.sink   vertex,
	bbs_stream_if.source bounds
);
	import bbs_pkg::*;

	localparam logic ST_RUN  = 1'b0;
	localparam logic ST_CALC = 1'b1;

	logic         state_q;
	logic         awaiting_q;
	bbs_box_t     box_q;
	logic         out_valid_q;
	bbs_result_t  out_q;

	bbs_vertex_t  vin;
	logic         in_acc;
	logic         load;
	bbs_rad_req_t rad_req;
	bbs_rad_rsp_t rad_rsp;

	assign vin          = vertex.payload;
	assign vertex.ready = (state_q == ST_RUN);
	assign in_acc       = vertex.valid && vertex.ready;
	assign load         = (state_q == ST_CALC) && rad_rsp.done
		&& (!out_valid_q || bounds.ready);

	assign rad_req.start = in_acc && vin.last_vertex;
	assign rad_req.ack   = load;

	bbs_radius u_radius (
		.clk    (clk),
		.arst_n (arst_n),
		.box    (box_q),
		.req    (rad_req),
		.rsp    (rad_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			awaiting_q  <= 1'b1;
			box_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				if (awaiting_q) begin
					box_q.min_x <= vin.pos_x;
					box_q.min_y <= vin.pos_y;
					box_q.min_z <= vin.pos_z;
					box_q.max_x <= vin.pos_x;
					box_q.max_y <= vin.pos_y;
					box_q.max_z <= vin.pos_z;
				end else begin
					if (vin.pos_x < box_q.min_x) box_q.min_x <= vin.pos_x;
					if (vin.pos_y < box_q.min_y) box_q.min_y <= vin.pos_y;
					if (vin.pos_z < box_q.min_z) box_q.min_z <= vin.pos_z;
					if (vin.pos_x > box_q.max_x) box_q.max_x <= vin.pos_x;
					if (vin.pos_y > box_q.max_y) box_q.max_y <= vin.pos_y;
					if (vin.pos_z > box_q.max_z) box_q.max_z <= vin.pos_z;
				end
				awaiting_q <= vin.last_vertex;
				if (vin.last_vertex) begin
					state_q <= ST_CALC;
				end
			end
			if (load) begin
				state_q     <= ST_RUN;
				out_valid_q <= 1'b1;
			end else if (bounds.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.min_x         <= box_q.min_x;
			out_q.min_y         <= box_q.min_y;
			out_q.min_z         <= box_q.min_z;
			out_q.max_x         <= box_q.max_x;
			out_q.max_y         <= box_q.max_y;
			out_q.max_z         <= box_q.max_z;
			out_q.center_x      <= rad_rsp.cen_x;
			out_q.center_y      <= rad_rsp.cen_y;
			out_q.center_z      <= rad_rsp.cen_z;
			out_q.sphere_radius <= rad_rsp.radius;
		end
	end

	assign bounds.valid   = out_valid_q;
	assign bounds.payload = out_q;

endmodule

/* rtl/bbs_radius.sv */
// box center and bounding sphere radius over a shared multiplier and root step
`timescale 1ns / 1ps
module bbs_radius (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bbs_pkg::bbs_box_t     box,
	input  bbs_pkg::bbs_rad_req_t req,
	output bbs_pkg::bbs_rad_rsp_t rsp
);
	import bbs_pkg::*;

	localparam logic [2:0] RS_IDLE = 3'd0;
	localparam logic [2:0] RS_PREP = 3'd1;
	localparam logic [2:0] RS_MUL  = 3'd2;
	localparam logic [2:0] RS_ROOT = 3'd3;
	localparam logic [2:0] RS_DONE = 3'd4;

	localparam int CNT_W = $clog2(ROOT_STEPS);
	localparam int REM_W = COORD_W + 1;

	logic [2:0]         state_q;
	logic [CNT_W-1:0]   cnt_q;
	coord_t             cen_x_q, cen_y_q, cen_z_q;
	logic [COORD_W-1:0] d_q [AXES];
	logic [SQ_W-1:0]    prod_q;
	logic [SQ_W-1:0]    acc_q;
	logic [SQ_W-1:0]    n_q;
	logic [REM_W-1:0]   rem_q;
	logic [COORD_W-1:0] root_q;

	logic [COORD_W-1:0] d_sel;
	logic [SQ_W-1:0]    sq;
	logic [REM_W+1:0]   rem_sh;
	logic [REM_W+1:0]   trial;
	logic [REM_W+1:0]   rem_sub;
	logic               ge;

	// floor of (a + b) / 2 on a widened sum
	function automatic coord_t half_sum(input coord_t a, input coord_t b);
		logic signed [COORD_W+1:0] s;
		begin
			s = {{2{a[COORD_W-1]}}, a} + {{2{b[COORD_W-1]}}, b};
			half_sum = s[COORD_W:1];
		end
	endfunction

	// hi - floor((lo + hi) / 2) equals floor((hi - lo + 1) / 2), never negative
	function automatic logic [COORD_W-1:0] half_span(input coord_t lo, input coord_t hi);
		logic signed [COORD_W+1:0] s;
		begin
			s = {{2{hi[COORD_W-1]}}, hi} - {{2{lo[COORD_W-1]}}, lo}
				+ (COORD_W+2)'(1);
			half_span = s[COORD_W:1];
		end
	endfunction

	always_comb begin
		case (cnt_q[1:0])
			2'd1:    d_sel = d_q[1];
			2'd2:    d_sel = d_q[2];
			default: d_sel = d_q[0];
		endcase
	end

	assign sq = d_sel * d_sel;

	assign rem_sh  = {rem_q, n_q[SQ_W-1 -: 2]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign ge      = (rem_sh >= trial);
	assign rem_sub = rem_sh - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RS_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				RS_IDLE: begin
					if (req.start) begin
						state_q <= RS_PREP;
					end
				end
				RS_PREP: begin
					state_q <= RS_MUL;
					cnt_q   <= '0;
				end
				RS_MUL: begin
					if (cnt_q == CNT_W'(AXES)) begin
						state_q <= RS_ROOT;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				RS_ROOT: begin
					if (cnt_q == CNT_W'(ROOT_STEPS - 1)) begin
						state_q <= RS_DONE;
					end
					cnt_q <= cnt_q + CNT_W'(1);
				end
				RS_DONE: begin
					if (req.ack) begin
						state_q <= RS_IDLE;
					end
				end
				default: state_q <= RS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			RS_PREP: begin
				cen_x_q <= half_sum(box.min_x, box.max_x);
				cen_y_q <= half_sum(box.min_y, box.max_y);
				cen_z_q <= half_sum(box.min_z, box.max_z);
				d_q[0]  <= half_span(box.min_x, box.max_x);
				d_q[1]  <= half_span(box.min_y, box.max_y);
				d_q[2]  <= half_span(box.min_z, box.max_z);
				prod_q  <= '0;
				acc_q   <= '0;
			end
			RS_MUL: begin
				// the product is registered first and added to the sum in the next cycle
				prod_q <= sq;
				acc_q  <= acc_q + prod_q;
				if (cnt_q == CNT_W'(AXES)) begin
					n_q    <= acc_q + prod_q;
					rem_q  <= '0;
					root_q <= '0;
				end
			end
			RS_ROOT: begin
				n_q    <= {n_q[SQ_W-3:0], 2'b00};
				rem_q  <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
				root_q <= {root_q[COORD_W-2:0], ge};
			end
			default: begin
			end
		endcase
	end

	assign rsp.done   = (state_q == RS_DONE);
	assign rsp.cen_x  = cen_x_q;
	assign rsp.cen_y  = cen_y_q;
	assign rsp.cen_z  = cen_z_q;
	assign rsp.radius = root_q;

endmodule

/* rtl/bbs_checker.sv */
// port-level checks for the bounding box and sphere block
`timescale 1ns / 1ps
module bbs_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 in_last,
	input logic                 out_valid,
	input logic                 out_ready,
	input bbs_pkg::bbs_result_t out_data
);
	import bbs_pkg::*;

	// a result waiting on the receiver stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	// an ordinary vertex never stalls the stream
	a_run_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_last |=> in_ready)
		else $error("ready dropped after a non-last vertex");

	// a last vertex hands the block over to the radius computation
	a_calc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("ready held after a last vertex");

	// box corners are ordered on every axis
	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.min_x <= out_data.max_x)
			&& (out_data.min_y <= out_data.max_y)
			&& (out_data.min_z <= out_data.max_z))
		else $error("result box corners out of order");

endmodule

bind bounding_box_and_sphere_unit bbs_checker u_bbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (vertex.valid),
	.in_ready  (vertex.ready),
	.in_last   (vertex.payload.last_vertex),
	.out_valid (bounds.valid),
	.out_ready (bounds.ready),
	.out_data  (bounds.payload)
);
